/* src/rsa_pkg.sv */
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants for the RPN stack ALU: beat payloads, command
// and error codes, sequencer states and the serial ALU handshake.
// ----------------------------------------------------------------------------
package rsa_pkg;

    localparam int DATA_W  = 32;
    localparam int DEPTH_W = 7;
    localparam int CNT_W   = 6;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W);

    typedef enum logic [2:0] {
        CMD_PUSH = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_REM  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_UNDER = 2'd1,
        ERR_OVER  = 2'd2,
        ERR_DIVZ  = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_EXEC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] push_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       stack_depth;
        logic [1:0]               error_code;
    } t_out_beat;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } t_alu_req;

    typedef struct packed {
        logic done;
    } t_alu_rsp;

endpackage

/* src/rsa_stack_mem.sv */
// ----------------------------------------------------------------------------
// rsa_stack_mem
// Stack storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rsa_stack_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [rsa_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [rsa_pkg::DATA_W-1:0] o_rdata
);

    logic [rsa_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [rsa_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/rsa_serial_alu.sv */
// ----------------------------------------------------------------------------
// rsa_serial_alu
// Serial arithmetic unit: add/sub one bit per cycle, multiply by shift-add,
// divide/remainder by restoring division on magnitudes, 32 steps each, then
// sign fixup and the done pulse.
// ----------------------------------------------------------------------------
module rsa_serial_alu (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rsa_pkg::t_alu_req          i_req,
    input  logic [rsa_pkg::DATA_W-1:0] i_a,
    input  logic [rsa_pkg::DATA_W-1:0] i_b,
    output rsa_pkg::t_alu_rsp          o_rsp,
    output logic [rsa_pkg::DATA_W-1:0] o_result
);

    localparam int W = rsa_pkg::DATA_W;

    logic [W-1:0]                r_a, n_a;
    logic [W-1:0]                r_b, n_b;
    logic [W-1:0]                r_acc, n_acc;
    logic [W-1:0]                r_rem, n_rem;
    logic [W-1:0]                r_res, n_res;
    logic [2:0]                  r_op, n_op;
    logic [rsa_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                        r_carry, n_carry;
    logic                        r_neg, n_neg;
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;

    logic [W-1:0] mag_a;
    logic [W-1:0] mag_b;
    logic [W:0]   rem_sh;
    logic [W:0]   diff;
    logic         sbit;
    logic         cbit;

    assign mag_a  = i_a[W-1] ? (~i_a + W'(1)) : i_a;
    assign mag_b  = i_b[W-1] ? (~i_b + W'(1)) : i_b;
    assign rem_sh = {r_rem, r_a[W-1]};
    assign diff   = rem_sh - {1'b0, r_b};
    assign sbit   = r_a[0] ^ r_b[0] ^ r_carry;
    assign cbit   = (r_a[0] & r_b[0]) | (r_carry & (r_a[0] ^ r_b[0]));

    always_comb begin
        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_res   = r_res;
        n_op    = r_op;
        n_cnt   = r_cnt;
        n_carry = r_carry;
        n_neg   = r_neg;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_op    = i_req.op;
            n_cnt   = '0;
            n_busy  = 1'b1;
            n_acc   = '0;
            n_rem   = '0;
            n_carry = (i_req.op == rsa_pkg::CMD_SUB);
            n_a     = i_a;
            n_b     = (i_req.op == rsa_pkg::CMD_SUB) ? ~i_b : i_b;
            n_neg   = 1'b0;
            if (i_req.op inside {rsa_pkg::CMD_DIV, rsa_pkg::CMD_REM}) begin
                n_a   = mag_a;
                n_b   = mag_b;
                n_neg = (i_req.op == rsa_pkg::CMD_DIV) ? (i_a[W-1] ^ i_b[W-1]) : i_a[W-1];
            end
        end else if (r_busy) begin
            if (r_cnt == rsa_pkg::CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                case (r_op)
                    rsa_pkg::CMD_DIV: n_res = r_neg ? (~r_acc + W'(1)) : r_acc;
                    rsa_pkg::CMD_REM: n_res = r_neg ? (~r_rem + W'(1)) : r_rem;
                    default:          n_res = r_acc;
                endcase
            end else begin
                n_cnt = r_cnt + rsa_pkg::CNT_W'(1);
                case (r_op)
                    rsa_pkg::CMD_ADD, rsa_pkg::CMD_SUB: begin
                        n_carry = cbit;
                        n_acc   = {sbit, r_acc[W-1:1]};
                        n_a     = r_a >> 1;
                        n_b     = r_b >> 1;
                    end
                    rsa_pkg::CMD_MUL: begin
                        if (r_b[0]) begin
                            n_acc = r_acc + r_a;
                        end
                        n_a = r_a << 1;
                        n_b = r_b >> 1;
                    end
                    rsa_pkg::CMD_DIV, rsa_pkg::CMD_REM: begin
                        n_rem = diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
                        n_acc = {r_acc[W-2:0], ~diff[W]};
                        n_a   = r_a << 1;
                    end
                    default: begin
                        n_acc = r_acc;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_a     <= n_a;
        r_b     <= n_b;
        r_acc   <= n_acc;
        r_rem   <= n_rem;
        r_res   <= n_res;
        r_op    <= n_op;
        r_cnt   <= n_cnt;
        r_carry <= n_carry;
        r_neg   <= n_neg;
    end

    assign o_rsp.done = r_done;
    assign o_result   = r_res;

endmodule

/* src/rpn_stack_alu_core.sv */
// Flow: push, error and no-op beats go from IDLE through DECODE to DONE,
// which loads the output register; add/sub/mul/div/rem also pass FETCH,
// which starts the 32-step serial ALU on the stack read, and EXEC, which
// writes the result back. One beat is in flight; the next is taken in IDLE.
// A new input beat is taken while a finished result waits in the output reg.
// Reset (synchronous, active low) empties the stack; store contents are kept.
// ----------------------------------------------------------------------------
// rpn_stack_alu_core
// Reverse-Polish integer evaluator over a bounded stack of 32-bit values,
// with a cached top-of-stack register and a bit-serial arithmetic unit.
// ----------------------------------------------------------------------------
module rpn_stack_alu_core #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rsa_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rsa_pkg::t_out_beat o_out_data
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int W   = rsa_pkg::DATA_W;

    rsa_pkg::t_state    r_state, n_state;
    logic [SPW-1:0]     r_sp, n_sp;
    logic [W-1:0]       r_top, n_top;
    logic [2:0]         r_cmd, n_cmd;
    logic [W-1:0]       r_val, n_val;
    logic [1:0]         r_err, n_err;
    logic               r_out_valid, n_out_valid;
    rsa_pkg::t_out_beat r_out, n_out;

    logic [SPW-1:0]     sp_m2;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [W-1:0]       mem_wdata;
    logic [W-1:0]       mem_rdata;
    rsa_pkg::t_alu_req  alu_req;
    rsa_pkg::t_alu_rsp  alu_rsp;
    logic [W-1:0]       alu_result;

    assign sp_m2 = r_sp - SPW'(2);

    rsa_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (sp_m2[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    rsa_serial_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (mem_rdata),
        .i_b      (r_top),
        .o_rsp    (alu_rsp),
        .o_result (alu_result)
    );

    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_top       = r_top;
        n_cmd       = r_cmd;
        n_val       = r_val;
        n_err       = r_err;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_out       = r_out;
        o_in_ready  = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_sp[AW-1:0];
        mem_wdata   = r_val;
        alu_req     = '0;
        alu_req.op  = r_cmd;
        case (r_state)
            rsa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd   = i_in_data.command;
                    n_val   = i_in_data.push_value;
                    n_state = rsa_pkg::S_DECODE;
                end
            end
            rsa_pkg::S_DECODE: begin
                n_err   = rsa_pkg::ERR_OK;
                n_state = rsa_pkg::S_DONE;
                if (r_cmd == rsa_pkg::CMD_PUSH) begin
                    if (r_sp == SPW'(STACK_DEPTH)) begin
                        n_err = rsa_pkg::ERR_OVER;
                    end else begin
                        mem_we = 1'b1;
                        n_top  = r_val;
                        n_sp   = r_sp + SPW'(1);
                    end
                end else if (r_cmd inside {[rsa_pkg::CMD_ADD:rsa_pkg::CMD_REM]}) begin
                    if (r_sp < SPW'(2)) begin
                        n_err = rsa_pkg::ERR_UNDER;
                    end else if ((r_cmd inside {rsa_pkg::CMD_DIV, rsa_pkg::CMD_REM})
                                 && (r_top == '0)) begin
                        n_err = rsa_pkg::ERR_DIVZ;
                    end else begin
                        n_state = rsa_pkg::S_FETCH;
                    end
                end
            end
            rsa_pkg::S_FETCH: begin
                alu_req.start = 1'b1;
                n_state       = rsa_pkg::S_EXEC;
            end
            rsa_pkg::S_EXEC: begin
                if (alu_rsp.done) begin
                    mem_we    = 1'b1;
                    mem_waddr = sp_m2[AW-1:0];
                    mem_wdata = alu_result;
                    n_top     = alu_result;
                    n_sp      = r_sp - SPW'(1);
                    n_state   = rsa_pkg::S_DONE;
                end
            end
            rsa_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.top_value   = (r_sp != '0) ? r_top : '0;
                    n_out.stack_depth = rsa_pkg::DEPTH_W'(r_sp);
                    n_out.error_code  = r_err;
                    n_state           = rsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rsa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsa_pkg::S_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
        r_top <= n_top;
        r_cmd <= n_cmd;
        r_val <= n_val;
        r_err <= n_err;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_done_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == rsa_pkg::S_EXEC))
        else $error("ALU done outside execute state");

    a_pop_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsa_pkg::S_EXEC && alu_rsp.done) |=> (r_sp == $past(r_sp) - SPW'(1)))
        else $error("stack pointer not decremented on writeback");

endmodule

/* bench/rpn_beat_checker.sv */
// ----------------------------------------------------------------------------
// rpn_beat_checker
// Watches both channels of the RPN stack ALU. It keeps its own copy of the
// stack, works out the expected result of every accepted input beat, and
// compares each accepted output beat field by field with the oldest one.
// ----------------------------------------------------------------------------
module rpn_beat_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  rsa_pkg::t_in_beat  i_in_beat,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  rsa_pkg::t_out_beat i_out_beat,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    logic [rsa_pkg::DATA_W-1:0] stack_copy [STACK_DEPTH];
    int unsigned                depth_copy = 0;
    rsa_pkg::t_out_beat         pending_results [$];
    int                         n_fail     = 0;
    int                         n_pending  = 0;
    int                         n_checked  = 0;

    assign o_fail_count = n_fail;
    assign o_pending    = n_pending;
    assign o_checked    = n_checked;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH result %0d, %s: got 0x%h, expected 0x%h",
                 $realtime, n_checked, what, got, want);
        n_fail++;
    endtask

    // Signed wrap-around arithmetic; divide truncates toward zero and the
    // remainder follows the dividend's sign.
    function automatic logic [31:0] rpn_arith(input logic [2:0] op,
                                              input logic [31:0] lhs,
                                              input logic [31:0] rhs);
        logic [31:0] mag_l;
        logic [31:0] mag_r;
        logic [31:0] q;
        mag_l = lhs[31] ? (32'd0 - lhs) : lhs;
        mag_r = rhs[31] ? (32'd0 - rhs) : rhs;
        case (op)
            rsa_pkg::CMD_ADD: return lhs + rhs;
            rsa_pkg::CMD_SUB: return lhs - rhs;
            rsa_pkg::CMD_MUL: return lhs * rhs;
            rsa_pkg::CMD_DIV: begin
                q = mag_l / mag_r;
                return (lhs[31] ^ rhs[31]) ? (32'd0 - q) : q;
            end
            default: begin
                q = mag_l % mag_r;
                return lhs[31] ? (32'd0 - q) : q;
            end
        endcase
    endfunction

    function automatic rsa_pkg::t_out_beat eval_rpn_step(input rsa_pkg::t_in_beat b);
        rsa_pkg::t_out_beat r;
        logic [31:0]        lhs;
        logic [31:0]        rhs;
        logic               is_div;
        r.error_code = rsa_pkg::ERR_OK;
        is_div = (b.command == rsa_pkg::CMD_DIV) || (b.command == rsa_pkg::CMD_REM);
        case (b.command)
            rsa_pkg::CMD_PUSH: begin
                if (depth_copy >= STACK_DEPTH) begin
                    r.error_code = rsa_pkg::ERR_OVER;
                end else begin
                    stack_copy[depth_copy] = b.push_value;
                    depth_copy++;
                end
            end
            rsa_pkg::CMD_ADD, rsa_pkg::CMD_SUB, rsa_pkg::CMD_MUL,
            rsa_pkg::CMD_DIV, rsa_pkg::CMD_REM: begin
                if (depth_copy < 2) begin
                    r.error_code = rsa_pkg::ERR_UNDER;
                end else begin
                    rhs = stack_copy[depth_copy - 1];
                    lhs = stack_copy[depth_copy - 2];
                    if (is_div && rhs == '0) begin
                        r.error_code = rsa_pkg::ERR_DIVZ;
                    end else begin
                        stack_copy[depth_copy - 2] = rpn_arith(b.command, lhs, rhs);
                        depth_copy--;
                    end
                end
            end
            default: ;
        endcase
        r.top_value   = (depth_copy > 0) ? stack_copy[depth_copy - 1] : '0;
        r.stack_depth = rsa_pkg::DEPTH_W'(depth_copy);
        return r;
    endfunction

    always @(posedge i_clk) begin
        rsa_pkg::t_out_beat want;
        logic               in_fire;
        logic               out_fire;
        in_fire  = i_in_valid && i_in_ready;
        out_fire = i_out_valid && i_out_ready;
        if (!i_rst_n) begin
            depth_copy = 0;
            pending_results.delete();
            n_pending <= 0;
        end else begin
            if (out_fire) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with nothing pending",
                                    i_out_beat.top_value, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_beat.top_value !== want.top_value)
                        report_mismatch("top_value", i_out_beat.top_value,
                                        want.top_value);
                    if (i_out_beat.stack_depth !== want.stack_depth)
                        report_mismatch("stack_depth", 32'(i_out_beat.stack_depth),
                                        32'(want.stack_depth));
                    if (i_out_beat.error_code !== want.error_code)
                        report_mismatch("error_code", 32'(i_out_beat.error_code),
                                        32'(want.error_code));
                end
                n_checked++;
            end
            if (in_fire)
                pending_results.push_back(eval_rpn_step(i_in_beat));
            n_pending <= n_pending + int'(in_fire) - int'(out_fire);
        end
    end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for rpn_stack_alu_core: directed corner cases, a
// full-stack fill under a long output stall, then random RPN expressions
// with random idle gaps on both channels. Checking is done by
// rpn_beat_checker.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          STACK_DEPTH  = 64;
    localparam int          N_ITEMS      = 450;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          LIMIT_CYCLES = 200000;
    localparam logic [2:0]  CMD_NOP_A    = 3'd6;
    localparam logic [2:0]  CMD_NOP_B    = 3'd7;
    localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_NEG1     = 32'hFFFF_FFFF;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    rsa_pkg::t_in_beat  in_beat   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    rsa_pkg::t_out_beat out_beat;

    int  fail_count;
    int  pending;
    int  checked;
    int  n_sent      = 0;
    int  n_cycles    = 0;
    int  hold_req    = 0;
    int  hold_done   = 0;
    bit  quiet       = 1'b0;

    rpn_stack_alu_core #(.STACK_DEPTH(STACK_DEPTH)) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat)
    );

    rpn_beat_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_beat   (out_beat),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return '0;
        if (r < 14) return 32'd1;
        if (r < 20) return VAL_NEG1;
        if (r < 25) return VAL_MIN;
        if (r < 30) return VAL_MAX;
        if (r < 60) return 32'($signed($urandom_range(0, 200)) - 100);
        return $urandom;
    endfunction

    // hi = 2 limits the choice to add, subtract and multiply
    function automatic logic [2:0] pick_op(input int hi);
        case ($urandom_range(0, hi))
            0:       return rsa_pkg::CMD_ADD;
            1:       return rsa_pkg::CMD_SUB;
            2:       return rsa_pkg::CMD_MUL;
            3:       return rsa_pkg::CMD_DIV;
            default: return rsa_pkg::CMD_REM;
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_beat(input logic [2:0] cmd, input logic [31:0] val);
        int gap;
        gap = quiet ? 0 : pick_idle();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        in_beat.command <= cmd;
        in_beat.push_value <= val;
        do @(posedge clk); while (!in_ready);
        n_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Output side: random stalls, plus a long hold-off on request.
    initial begin
        int gap;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_done != hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done++;
                out_ready <= 1'b1;
            end else begin
                gap = quiet ? 0 : pick_idle();
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        while (n_cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            n_cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", n_cycles, pending);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int k;
        int n_ops;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed corner cases
        send_beat(rsa_pkg::CMD_ADD, VAL_MAX);
        send_beat(rsa_pkg::CMD_PUSH, 32'd7);
        send_beat(rsa_pkg::CMD_MUL, '0);
        send_beat(rsa_pkg::CMD_PUSH, '0);
        send_beat(rsa_pkg::CMD_DIV, '0);
        send_beat(rsa_pkg::CMD_REM, VAL_NEG1);
        send_beat(rsa_pkg::CMD_ADD, '0);
        send_beat(rsa_pkg::CMD_PUSH, VAL_MIN);
        send_beat(rsa_pkg::CMD_PUSH, VAL_NEG1);
        send_beat(rsa_pkg::CMD_DIV, '0);
        send_beat(rsa_pkg::CMD_PUSH, VAL_NEG1);
        send_beat(rsa_pkg::CMD_REM, '0);
        send_beat(rsa_pkg::CMD_PUSH, VAL_MAX);
        send_beat(rsa_pkg::CMD_PUSH, VAL_MAX);
        send_beat(rsa_pkg::CMD_MUL, '0);
        send_beat(rsa_pkg::CMD_PUSH, VAL_MIN);
        send_beat(rsa_pkg::CMD_SUB, '0);
        send_beat(rsa_pkg::CMD_PUSH, -32'sd7);
        send_beat(rsa_pkg::CMD_DIV, '0);
        send_beat(rsa_pkg::CMD_PUSH, -32'sd3);
        send_beat(rsa_pkg::CMD_REM, '0);
        send_beat(CMD_NOP_A, VAL_MIN);
        send_beat(CMD_NOP_B, VAL_NEG1);
        send_beat(rsa_pkg::CMD_PUSH, -32'sd7);
        send_beat(rsa_pkg::CMD_PUSH, 32'd2);
        send_beat(rsa_pkg::CMD_REM, '0);
        wait_drained();

        // fill past the top while the output side is held off, then fold down
        quiet = 1'b1;
        hold_req++;
        repeat (STACK_DEPTH + 2) send_beat(rsa_pkg::CMD_PUSH, pick_value());
        repeat (STACK_DEPTH + 4) send_beat(pick_op(2), pick_value());
        quiet = 1'b0;

        // random expressions with some noise beats mixed in
        while (n_sent < N_ITEMS) begin
            quiet = ($urandom_range(0, 6) == 0);
            if ($urandom_range(0, 4) == 0) begin
                send_beat(3'($urandom_range(0, 7)), pick_value());
            end else begin
                k     = $urandom_range(2, 6);
                n_ops = k - 1 + $urandom_range(0, 1);
                repeat (k) send_beat(rsa_pkg::CMD_PUSH, pick_value());
                repeat (n_ops) send_beat(pick_op(4), pick_value());
            end
        end
        quiet = 1'b0;

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Covered %0d input beats: stack corner cases, a full-stack fill under a",
                 n_sent);
        $display("long output stall, and random RPN expressions; %0d results compared.",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
